@@ rtl/core/ir_pulse_distance_decoder_defines.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

`ifndef SYNTH

`define IPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ipd assertion failed");

`define IPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ipd assertion failed");

`else

`define IPD_ASSERT(label, clk, rst, prop)

`define IPD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/core/ipd_pkg.sv @@
package ipd_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int KEY_BITS       = 8;
   localparam int REG_W          = 16;
   localparam int NUM_REGS       = 6;
   localparam int REG_IDX_W      = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W     = $clog2(4 * NUM_REGS);
   localparam int CSR_DATA_W     = 32;
   localparam int CMP_W          = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
   localparam int KEY_CODE_W     = 8;
   localparam int REPEAT_COUNT_W = 16;
   localparam int HIST_W         = 3;
   localparam int REQ_TDATA_W    = 8;
   localparam int RSP_TDATA_W    = 32;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_RUNT      = 3'd0,
      REG_ZERO      = 3'd1,
      REG_ONE       = 3'd2,
      REG_HEADER    = 3'd3,
      REG_FRAME_END = 3'd4,
      REG_IDLE      = 3'd5
   } reg_idx_type;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      16'd8, 16'd18, 16'd26, 16'd150, 16'd420, 16'd1200
   };

   typedef logic [NUM_REGS-1:0][REG_W-1:0] thr_type;

   typedef enum logic [2:0] {
      IVAL_RUNT      = 3'd0,
      IVAL_ZERO      = 3'd1,
      IVAL_ONE       = 3'd2,
      IVAL_HEADER    = 3'd3,
      IVAL_FRAME_END = 3'd4,
      IVAL_REPEAT    = 3'd5,
      IVAL_TOO_LONG  = 3'd6
   } ival_class_type;

   typedef struct packed {
      logic           idle_over;
      ival_class_type ival_class;
   } class_result_type;

   // first field sits in the high bits
   typedef struct packed {
      logic key_taken;
      logic pin_sample;
   } req_item_type;

   typedef struct packed {
      logic                      line_level;
      logic [REPEAT_COUNT_W-1:0] repeat_count;
      logic                      repeat_active;
      logic                      key_pending;
      logic [KEY_CODE_W-1:0]     key_code;
      logic                      key_valid;
   } rsp_item_type;

endpackage

@@ rtl/core/ipd_csr.sv @@
module ipd_csr
   import ipd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output thr_type               thr
);

   logic [REG_W-1:0]     regs_ff [NUM_REGS];
   logic [REG_W-1:0]     regs_in [NUM_REGS];
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 wr_en;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (wr_en && (csr_idx == REG_IDX_W'(i))) begin
            regs_in[i] = csr_pwdata[REG_W-1:0];
         end
         thr[i] = regs_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) begin
            regs_ff[i] <= REG_RESET[i];
         end else begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (int'(csr_idx) < NUM_REGS) begin
         csr_prdata = CSR_DATA_W'(regs_ff[csr_idx]);
      end
   end

endmodule

@@ rtl/core/ipd_classify.sv @@
module ipd_classify
   import ipd_pkg::*;
(
   input  logic [COUNT_WIDTH-1:0] count,
   input  thr_type                thr,
   output class_result_type       cls
);

   logic [CMP_W-1:0]    count_x;
   logic [NUM_REGS-1:0] le;

   assign count_x = CMP_W'(count);

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         le[i] = count_x <= CMP_W'(thr[i]);
      end
   end

   // first threshold that holds wins, even if unordered
   always_comb begin
      priority if (le[REG_RUNT]) begin
         cls.ival_class = IVAL_RUNT;
      end else if (le[REG_ZERO]) begin
         cls.ival_class = IVAL_ZERO;
      end else if (le[REG_ONE]) begin
         cls.ival_class = IVAL_ONE;
      end else if (le[REG_HEADER]) begin
         cls.ival_class = IVAL_HEADER;
      end else if (le[REG_FRAME_END]) begin
         cls.ival_class = IVAL_FRAME_END;
      end else if (le[REG_IDLE]) begin
         cls.ival_class = IVAL_REPEAT;
      end else begin
         cls.ival_class = IVAL_TOO_LONG;
      end
      cls.idle_over = ~le[REG_IDLE];
   end

endmodule

@@ rtl/core/ipd_core.sv @@
`include "ir_pulse_distance_decoder_defines.svh"

module ipd_core
   import ipd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  thr_type      thr,
   output rsp_item_type result
);

   logic [HIST_W-1:0]      hist_ff,    hist_in;
   logic                   level_ff,   level_in;
   logic                   prev_ff,    prev_in;
   logic [COUNT_WIDTH-1:0] cnt_ff,     cnt_in;
   logic [KEY_BITS-1:0]    bits_ff,    bits_in;
   logic                   pending_ff, pending_in;
   logic [KEY_BITS-1:0]    held_ff,    held_in;
   logic                   repeat_ff,  repeat_in;
   logic [COUNT_WIDTH-1:0] press_ff,   press_in;

   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic                   pend_clr;
   logic                   deliver;
   class_result_type       cls;

   assign pend_clr = item.key_taken ? 1'b0 : pending_ff;
   assign cnt_inc  = (cnt_ff != {COUNT_WIDTH{1'b1}}) ? cnt_ff + COUNT_WIDTH'(1) : cnt_ff;

   ipd_classify u_classify (
      .count (cnt_inc),
      .thr   (thr),
      .cls   (cls)
   );

   always_comb begin
      hist_in    = {hist_ff[HIST_W-2:0], item.pin_sample};
      level_in   = level_ff;
      if (hist_in == {HIST_W{1'b1}}) begin
         level_in = 1'b1;
      end else if (hist_in == '0) begin
         level_in = 1'b0;
      end
      prev_in    = level_in;
      cnt_in     = cnt_inc;
      bits_in    = bits_ff;
      pending_in = pend_clr;
      held_in    = held_ff;
      repeat_in  = repeat_ff;
      press_in   = press_ff;
      deliver    = 1'b0;

      if (level_in) begin
         if (cls.idle_over) begin
            deliver   = (bits_ff != '0) && !pend_clr;
            repeat_in = 1'b0;
         end
      end else if (prev_ff) begin
         cnt_in = '0;
         unique case (cls.ival_class)
            IVAL_ZERO: begin
               bits_in = {bits_ff[KEY_BITS-2:0], 1'b0};
            end
            IVAL_ONE: begin
               bits_in = {bits_ff[KEY_BITS-2:0], 1'b1};
            end
            IVAL_FRAME_END: begin
               if (!pend_clr) begin
                  deliver   = 1'b1;
                  repeat_in = 1'b1;
                  press_in  = '0;
               end
            end
            IVAL_REPEAT: begin
               press_in = press_ff + COUNT_WIDTH'(1);
            end
            default: begin
            end
         endcase
      end

      if (deliver) begin
         held_in    = ~bits_ff;
         bits_in    = '0;
         pending_in = 1'b1;
      end

      result.key_valid     = deliver;
      result.key_code      = held_in[KEY_CODE_W-1:0];
      result.key_pending   = pending_in;
      result.repeat_active = repeat_in;
      result.repeat_count  = press_in[REPEAT_COUNT_W-1:0];
      result.line_level    = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         level_ff   <= 1'b0;
         prev_ff    <= 1'b0;
         cnt_ff     <= '0;
         bits_ff    <= '0;
         pending_ff <= 1'b0;
         held_ff    <= '0;
         repeat_ff  <= 1'b0;
         press_ff   <= '0;
      end else if (step) begin
         hist_ff    <= hist_in;
         level_ff   <= level_in;
         prev_ff    <= prev_in;
         cnt_ff     <= cnt_in;
         bits_ff    <= bits_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
         repeat_ff  <= repeat_in;
         press_ff   <= press_in;
      end
   end

   `IPD_ASSERT(a_deliver_sets_pending, clock, reset, step && result.key_valid |=> pending_ff && (bits_ff == '0))
   `IPD_ASSERT(a_deliver_inverts_bits, clock, reset, step && result.key_valid |=> held_ff == ~$past(bits_ff))
   `IPD_ASSERT(a_no_deliver_while_pending, clock, reset, step && pending_ff && !item.key_taken |-> !result.key_valid)

endmodule

@@ rtl/core/ir_pulse_distance_decoder.sv @@
// Channel   Dir  Handshake            Payload
// req_*     in   req_tvalid/tready    tick sample: pin_sample, key_taken
// rsp_*     out  rsp_tvalid/tready    one result item per tick
// csr_*     in   APB write/read       six 16-bit thresholds at 4*i
//
// One item per cycle sustained while rsp_tready holds; an item passes from req to rsp
// through the input register, then the result register after the decode logic.
// Synchronous reset clears the state and restores threshold defaults.
// A stalled rsp holds its item; the input register still takes one more item.
`include "ir_pulse_distance_decoder_defines.svh"

module ir_pulse_distance_decoder
   import ipd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [0] pin_sample, [1] key_taken
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] key_valid, [8:1] key_code, [9] key_pending, [10] repeat_active,
   // [26:11] repeat_count, [27] line_level
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic         in_valid_ff,  in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         req_acc;
   logic         advance;
   thr_type      thr;
   rsp_item_type result;

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_item_ff);

   ipd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .thr         (thr)
   );

   ipd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .thr    (thr),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_acc) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

endmodule
